### rtl/core/pid_controller_filtered_derivative_macros.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent assertion wrappers on clk / rst_n; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_FILTERED_DERIVATIVE_MACROS_SVH
`define PID_CONTROLLER_FILTERED_DERIVATIVE_MACROS_SVH
`ifndef SYNTHESIS
`define PIDFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pidfd assertion failed");
`define PIDFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pidfd assertion failed");
`else
`define PIDFD_ASSERT_IMP(lbl, ante, cons)
`define PIDFD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/core/pidfd_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Beat types, register map, fixed-point constants and saturation helper.
// ----------------------------------------------------------------------------
package pidfd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POLE_BITS = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [31:0] OUT_MIN_RST = 32'sh8000_0000;
  localparam logic signed [31:0] OUT_MAX_RST = 32'sh7fff_ffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_GAIN        = 3'd0,
    CFG_KI_HALF_PERIOD = 3'd1,
    CFG_KD_FILTER_GAIN = 3'd2,
    CFG_D_POLE         = 3'd3,
    CFG_OUT_MIN        = 3'd4,
    CFG_OUT_MAX        = 3'd5,
    CFG_SETPOINT       = 3'd6
  } cfg_idx_t;

  typedef enum logic [0:0] {
    CMD_UPDATE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic        [30:0] kp_gain;
    logic        [30:0] ki_half_period;
    logic        [30:0] kd_filter_gain;
    logic        [15:0] d_pole;
    logic signed [31:0] out_min;
    logic signed [31:0] out_max;
    logic signed [31:0] setpoint;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RST = '{
    kp_gain:        '0,
    ki_half_period: '0,
    kd_filter_gain: '0,
    d_pole:         '0,
    out_min:        OUT_MIN_RST,
    out_max:        OUT_MAX_RST,
    setpoint:       '0
  };

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] error_value;
    logic signed [31:0] p_term;
    logic signed [31:0] i_term;
    logic signed [31:0] d_term;
  } out_beat_t;

  // front stage -> loop stage
  typedef struct packed {
    logic               clr;
    logic signed [31:0] err;
    logic signed [63:0] kp_prod;
    logic signed [63:0] ki_prod;
    logic signed [63:0] kd_prod;
  } prod_beat_t;

  // loop stage -> output stage
  typedef struct packed {
    logic               clr;
    logic signed [31:0] err;
    logic signed [31:0] p_term;
    logic signed [31:0] i_term;
    logic signed [31:0] d_term;
  } term_beat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] res;
    if (x > 64'sh0000_0000_7fff_ffff) begin
      res = OUT_MAX_RST;
    end else if (x < 64'shffff_ffff_8000_0000) begin
      res = OUT_MIN_RST;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

endpackage

### rtl/core/pidfd_front.sv
// ----------------------------------------------------------------------------
// PID controller front stage
// Error, error history sum, measurement delta and the three gain products.
// ----------------------------------------------------------------------------
module pidfd_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  pidfd_pkg::cfg_regs_t   cfg,
  input  pidfd_pkg::in_beat_t    src,
  output pidfd_pkg::prod_beat_t  dst
);

  logic signed [31:0] meas, setpt, err;
  logic signed [31:0] last_err_r, last_err_nxt, last_meas_r, last_meas_nxt;
  logic signed [32:0] sp_diff, err_sum, meas_delta;
  logic signed [31:0] kp_s, ki_s, kd_s;
  logic signed [63:0] kp_prod, ki_prod, kd_prod;
  logic               is_clr;
  pidfd_pkg::prod_beat_t dst_r, dst_nxt;

  assign meas   = src.sample;
  assign setpt  = cfg.setpoint;
  assign is_clr = (src.command == pidfd_pkg::CMD_CLEAR);

  assign sp_diff    = {setpt[31], setpt} - {meas[31], meas};
  assign err        = pidfd_pkg::sat32({{31{sp_diff[32]}}, sp_diff});
  assign err_sum    = {err[31], err} + {last_err_r[31], last_err_r};
  assign meas_delta = {meas[31], meas} - {last_meas_r[31], last_meas_r};

  assign kp_s = {1'b0, cfg.kp_gain};
  assign ki_s = {1'b0, cfg.ki_half_period};
  assign kd_s = {1'b0, cfg.kd_filter_gain};

  assign kp_prod = kp_s * err;
  assign ki_prod = ki_s * err_sum;
  assign kd_prod = kd_s * meas_delta;

  always_comb begin
    last_err_nxt  = last_err_r;
    last_meas_nxt = last_meas_r;
    dst_nxt       = dst_r;
    if (load) begin
      last_meas_nxt = meas;
      last_err_nxt  = is_clr ? 32'sd0 : err;
      dst_nxt = '{clr: is_clr, err: err, kp_prod: kp_prod, ki_prod: ki_prod,
                  kd_prod: kd_prod};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r  <= '0;
      last_meas_r <= '0;
    end else begin
      last_err_r  <= last_err_nxt;
      last_meas_r <= last_meas_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r <= dst_nxt;
  end

  assign dst = dst_r;

endmodule

### rtl/core/pidfd_loop.sv
// ----------------------------------------------------------------------------
// PID controller loop stage
// Proportional term, anti-windup integrator and filtered derivative state.
// ----------------------------------------------------------------------------
module pidfd_loop (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  pidfd_pkg::cfg_regs_t   cfg,
  input  pidfd_pkg::prod_beat_t  src,
  output pidfd_pkg::term_beat_t  dst
);

  logic signed [63:0] kp_prod, ki_prod, kd_prod, ki_sh, kd_sh, i_acc, d_acc;
  logic signed [31:0] p, i_raw, i_lo, i_cl, lo_lim, hi_lim, d;
  logic signed [31:0] out_min, out_max;
  logic signed [31:0] integ_r, integ_nxt, deriv_r, deriv_nxt;
  logic signed [32:0] lo_diff, hi_diff;
  logic signed [16:0] pole_s;
  logic signed [48:0] pole_prod, pole_sh;
  pidfd_pkg::term_beat_t dst_r, dst_nxt;

  assign kp_prod = src.kp_prod;
  assign ki_prod = src.ki_prod;
  assign kd_prod = src.kd_prod;
  assign out_min = cfg.out_min;
  assign out_max = cfg.out_max;

  assign p = pidfd_pkg::sat32(kp_prod >>> pidfd_pkg::FRAC_BITS);

  // integrator with anti-windup limits around p
  assign ki_sh   = ki_prod >>> pidfd_pkg::FRAC_BITS;
  assign i_acc   = {{32{integ_r[31]}}, integ_r} + ki_sh;
  assign i_raw   = pidfd_pkg::sat32(i_acc);
  assign lo_diff = {out_min[31], out_min} - {p[31], p};
  assign hi_diff = {out_max[31], out_max} - {p[31], p};
  assign lo_lim  = (p > out_min) ? pidfd_pkg::sat32({{31{lo_diff[32]}}, lo_diff}) : 32'sd0;
  assign hi_lim  = (p < out_max) ? pidfd_pkg::sat32({{31{hi_diff[32]}}, hi_diff}) : 32'sd0;
  assign i_lo    = (i_raw < lo_lim) ? lo_lim : i_raw;
  assign i_cl    = (i_lo > hi_lim) ? hi_lim : i_lo;

  // derivative on measurement, first-order low-pass
  assign pole_s    = {1'b0, cfg.d_pole};
  assign pole_prod = pole_s * deriv_r;
  assign pole_sh   = pole_prod >>> pidfd_pkg::POLE_BITS;
  assign kd_sh     = kd_prod >>> pidfd_pkg::FRAC_BITS;
  assign d_acc     = {{15{pole_sh[48]}}, pole_sh} - kd_sh;
  assign d         = pidfd_pkg::sat32(d_acc);

  always_comb begin
    integ_nxt = integ_r;
    deriv_nxt = deriv_r;
    dst_nxt   = dst_r;
    if (load) begin
      if (src.clr) begin
        integ_nxt = '0;
        deriv_nxt = '0;
        dst_nxt   = '{clr: 1'b1, err: '0, p_term: '0, i_term: '0, d_term: '0};
      end else begin
        integ_nxt = i_cl;
        deriv_nxt = d;
        dst_nxt   = '{clr: 1'b0, err: src.err, p_term: p, i_term: i_cl, d_term: d};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      deriv_r <= '0;
    end else begin
      integ_r <= integ_nxt;
      deriv_r <= deriv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r <= dst_nxt;
  end

  assign dst = dst_r;

endmodule

### rtl/core/pid_controller_filtered_derivative.sv
// ----------------------------------------------------------------------------
// PID controller with filtered derivative
// Q16.16 PID with trapezoidal anti-windup integrator and low-pass derivative.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid / in_stall  in_data   (command, sample)
//   out_     out  out_valid/ out_stall out_data  (drive, error, p, i, d terms)
//   cfg_     in   cfg_we               cfg_index, cfg_wdata
//
// One beat per cycle sustained while out_stall is low; a result passes through
// the input reg, product stage, loop stage and output reg, in that order.
// The cycle is set by the integrator and derivative feedback in the loop stage.
// rst_n (sync) resets valid flags, config registers and controller state; data registers are not reset.
// out_stall backs the pipe up; in_stall rises only when all four stages hold a beat.
// ----------------------------------------------------------------------------
`include "pid_controller_filtered_derivative_macros.svh"

module pid_controller_filtered_derivative (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pidfd_pkg::in_beat_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pidfd_pkg::out_beat_t                out_data,
  input  logic                                cfg_we,
  input  logic [pidfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                         cfg_wdata
);

  pidfd_pkg::cfg_regs_t  cfg_r, cfg_nxt;
  pidfd_pkg::in_beat_t   s0_r, s0_nxt;
  pidfd_pkg::prod_beat_t s1_beat;
  pidfd_pkg::term_beat_t s2_r;
  pidfd_pkg::out_beat_t  out_data_r, out_data_nxt;

  logic s0_v_r, s0_v_nxt, s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt, out_valid_r, out_valid_nxt;
  logic out_ready, s2_ready, s1_ready, s0_ready;
  logic s0_adv, s1_adv, s2_adv, in_accept;

  logic signed [31:0] s2_p, s2_i, s2_d, cfg_min, cfg_max, drive_c;
  logic signed [33:0] sum_c, min_x, max_x, lo_c, hi_c;

  // ready chain
  assign out_ready = !out_valid_r || !out_stall;
  assign s2_adv    = s2_v_r && out_ready;
  assign s2_ready  = !s2_v_r || out_ready;
  assign s1_adv    = s1_v_r && s2_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign s0_adv    = s0_v_r && s1_ready;
  assign s0_ready  = !s0_v_r || s1_ready;
  assign in_stall  = !s0_ready;
  assign in_accept = in_valid && s0_ready;

  assign s0_v_nxt      = s0_ready  ? in_valid : s0_v_r;
  assign s1_v_nxt      = s1_ready  ? s0_v_r   : s1_v_r;
  assign s2_v_nxt      = s2_ready  ? s1_v_r   : s2_v_r;
  assign out_valid_nxt = out_ready ? s2_v_r   : out_valid_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pidfd_pkg::CFG_KP_GAIN:        cfg_nxt.kp_gain        = cfg_wdata[30:0];
        pidfd_pkg::CFG_KI_HALF_PERIOD: cfg_nxt.ki_half_period = cfg_wdata[30:0];
        pidfd_pkg::CFG_KD_FILTER_GAIN: cfg_nxt.kd_filter_gain = cfg_wdata[30:0];
        pidfd_pkg::CFG_D_POLE:         cfg_nxt.d_pole         = cfg_wdata[15:0];
        pidfd_pkg::CFG_OUT_MIN:        cfg_nxt.out_min        = cfg_wdata;
        pidfd_pkg::CFG_OUT_MAX:        cfg_nxt.out_max        = cfg_wdata;
        pidfd_pkg::CFG_SETPOINT:       cfg_nxt.setpoint       = cfg_wdata;
        default:                       cfg_nxt                = cfg_r;
      endcase
    end
  end

  assign s0_nxt = in_accept ? in_data : s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= pidfd_pkg::CFG_RST;
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s0_v_r      <= s0_v_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r       <= s0_nxt;
    out_data_r <= out_data_nxt;
  end

  pidfd_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (s0_adv),
    .cfg   (cfg_r),
    .src   (s0_r),
    .dst   (s1_beat)
  );

  pidfd_loop u_loop (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (s1_adv),
    .cfg   (cfg_r),
    .src   (s1_beat),
    .dst   (s2_r)
  );

  // drive = p + i + d, clamped to the output limits
  assign s2_p    = s2_r.p_term;
  assign s2_i    = s2_r.i_term;
  assign s2_d    = s2_r.d_term;
  assign cfg_min = cfg_r.out_min;
  assign cfg_max = cfg_r.out_max;
  assign sum_c   = {{2{s2_p[31]}}, s2_p} + {{2{s2_i[31]}}, s2_i} + {{2{s2_d[31]}}, s2_d};
  assign min_x   = {{2{cfg_min[31]}}, cfg_min};
  assign max_x   = {{2{cfg_max[31]}}, cfg_max};
  assign lo_c    = (sum_c < min_x) ? min_x : sum_c;
  assign hi_c    = (lo_c > max_x) ? max_x : lo_c;
  assign drive_c = hi_c[31:0];

  always_comb begin
    out_data_nxt = out_data_r;
    if (s2_adv) begin
      out_data_nxt = '{drive:       s2_r.clr ? 32'sd0 : drive_c,
                       error_value: s2_r.err,
                       p_term:      s2_r.p_term,
                       i_term:      s2_r.i_term,
                       d_term:      s2_r.d_term};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PIDFD_ASSERT_IMP(a_full_when_stalled, in_stall, s0_v_r && s1_v_r && s2_v_r && out_valid_r)
  `PIDFD_ASSERT_IMP(a_drive_in_range, s2_v_r && !s2_r.clr && (cfg_min <= cfg_max), (drive_c >= cfg_min) && (drive_c <= cfg_max))
  `PIDFD_ASSERT_NEXT(a_clear_zero_result, s2_adv && s2_r.clr, out_data_r == '0)

endmodule

### verif/tb_pid_controller_filtered_derivative.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID controller with filtered derivative testbench
// Drives update and clear beats through the in_ channel under random sender
// gaps and receiver stalls, predicts every result beat with a fixed-point
// model of the loop, and compares each field of each beat on the out_ channel.
// ----------------------------------------------------------------------------
module tb_pid_controller_filtered_derivative;
  import pidfd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1150;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_beat_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;

  // controller model state
  cfg_regs_t          ctl_cfg   = CFG_RST;
  logic signed [31:0] integ_acc = '0;
  logic signed [31:0] deriv_acc = '0;
  logic signed [31:0] prev_err  = '0;
  logic signed [31:0] prev_meas = '0;

  out_beat_t   expected_terms[$];
  out_beat_t   due_beat;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int          burst_left     = 0;
  bit          pacing         = 1'b1;
  int          hold_req       = 0;
  int          hold_left      = 0;
  int          mode_left      = 0;
  rx_mode_t    rx_mode        = RX_FREE;

  pid_controller_filtered_derivative DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [31:0] clip32(input logic signed [95:0] x);
    if (x > 96'sh7fff_ffff) return S32_MAX;
    if (x < -96'sh8000_0000) return S32_MIN;
    return x[31:0];
  endfunction

  function automatic out_beat_t predict_terms(input in_beat_t beat);
    logic signed [95:0] meas, err, p, i, d, lo, hi, drv, omin, omax;
    logic signed [95:0] kp_w, ki_w, kd_w, pole_w;
    out_beat_t res;
    meas   = $signed(beat.sample);
    omin   = $signed(ctl_cfg.out_min);
    omax   = $signed(ctl_cfg.out_max);
    kp_w   = {65'd0, ctl_cfg.kp_gain};
    ki_w   = {65'd0, ctl_cfg.ki_half_period};
    kd_w   = {65'd0, ctl_cfg.kd_filter_gain};
    pole_w = {80'd0, ctl_cfg.d_pole};
    res    = '0;
    if (beat.command == CMD_CLEAR) begin
      integ_acc = '0;
      deriv_acc = '0;
      prev_err  = '0;
      prev_meas = beat.sample;
    end else begin
      err = clip32($signed(ctl_cfg.setpoint) - meas);
      p   = clip32((kp_w * err) >>> FRAC_BITS);
      i   = clip32(integ_acc + ((ki_w * (err + prev_err)) >>> FRAC_BITS));
      // anti-windup window; the high bound wins when the two cross
      lo = 0;
      if (p > omin) lo = clip32(omin - p);
      hi = 0;
      if (p < omax) hi = clip32(omax - p);
      if (i < lo) i = lo;
      if (i > hi) i = hi;
      d = clip32(((pole_w * deriv_acc) >>> POLE_BITS) -
                 ((kd_w * (meas - prev_meas)) >>> FRAC_BITS));
      drv = p + i + d;
      if (drv < omin) drv = omin;
      if (drv > omax) drv = omax;
      integ_acc       = i[31:0];
      deriv_acc       = d[31:0];
      prev_err        = err[31:0];
      prev_meas       = beat.sample;
      res.drive       = drv[31:0];
      res.error_value = err[31:0];
      res.p_term      = p[31:0];
      res.i_term      = i[31:0];
      res.d_term      = d[31:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s expected %h got %h",
             cycle_count, what, want, got);
  endtask

  // result beat checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_terms.size() == 0) begin
        report_mismatch("unexpected beat, drive", 'x, out_data.drive);
      end else begin
        due_beat = expected_terms.pop_front();
        if (out_data.drive !== due_beat.drive)
          report_mismatch("drive", due_beat.drive, out_data.drive);
        if (out_data.error_value !== due_beat.error_value)
          report_mismatch("error_value", due_beat.error_value, out_data.error_value);
        if (out_data.p_term !== due_beat.p_term)
          report_mismatch("p_term", due_beat.p_term, out_data.p_term);
        if (out_data.i_term !== due_beat.i_term)
          report_mismatch("i_term", due_beat.i_term, out_data.i_term);
        if (out_data.d_term !== due_beat.d_term)
          report_mismatch("d_term", due_beat.d_term, out_data.d_term);
      end
    end
  end

  // receiver stall pattern, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(8, 150);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  task automatic send_item(input cmd_t cmd, input logic [31:0] value);
    in_beat_t beat;
    int gap;
    beat.command = cmd;
    beat.sample  = value;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_terms.push_back(predict_terms(beat));
    if (pacing) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 31);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_terms.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KP_GAIN:        ctl_cfg.kp_gain        = value[30:0];
      CFG_KI_HALF_PERIOD: ctl_cfg.ki_half_period = value[30:0];
      CFG_KD_FILTER_GAIN: ctl_cfg.kd_filter_gain = value[30:0];
      CFG_D_POLE:         ctl_cfg.d_pole         = value[15:0];
      CFG_OUT_MIN:        ctl_cfg.out_min        = value;
      CFG_OUT_MAX:        ctl_cfg.out_max        = value;
      CFG_SETPOINT:       ctl_cfg.setpoint       = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] kp, ki, kd, pole, omin, omax, sp);
    write_reg(CFG_KP_GAIN, kp);
    write_reg(CFG_KI_HALF_PERIOD, ki);
    write_reg(CFG_KD_FILTER_GAIN, kd);
    write_reg(CFG_D_POLE, pole);
    write_reg(CFG_OUT_MIN, omin);
    write_reg(CFG_OUT_MAX, omax);
    write_reg(CFG_SETPOINT, sp);
  endtask

  function automatic logic [31:0] rand_gain();
    logic [31:0] g;
    case ($urandom_range(0, 5))
      0:       g = '0;
      1:       g = 32'h7fff_ffff;
      2:       g = $urandom;
      3:       g = $urandom_range(0, 32'h0000_4000);
      default: g = $urandom_range(0, 32'h0004_0000);
    endcase
    g[31] = 1'($urandom_range(0, 1));
    return g;
  endfunction

  function automatic logic [31:0] rand_pole();
    logic [31:0] g;
    g = $urandom;
    case ($urandom_range(0, 4))
      0:       g[15:0] = '0;
      1:       g[15:0] = 16'hffff;
      2:       ;
      default: g[15:0] = 16'($urandom_range(49152, 65535));
    endcase
    return g;
  endfunction

  function automatic logic [31:0] rand_setpoint();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = S32_MIN;
      1:       v = S32_MAX;
      2:       v = $urandom;
      default: v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
    return v;
  endfunction

  // mostly near the setpoint so the loop stays out of saturation
  function automatic logic [31:0] rand_sample();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = S32_MIN;
      1:       v = S32_MAX;
      2, 3:    v = $urandom;
      default: v = ctl_cfg.setpoint + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
    return v;
  endfunction

  task automatic randomize_settings();
    logic [31:0] lo_lim, hi_lim;
    case ($urandom_range(0, 4))
      0: begin
        lo_lim = S32_MIN;
        hi_lim = S32_MAX;
      end
      1: begin
        lo_lim = $urandom;
        hi_lim = $urandom;
      end
      default: begin
        lo_lim = -$urandom_range(0, 32'h0100_0000);
        hi_lim = $urandom_range(0, 32'h0100_0000);
      end
    endcase
    apply_settings(rand_gain(), rand_gain(), rand_gain(), rand_pole(),
                   lo_lim, hi_lim, rand_setpoint());
  endtask

  // all gains zero after reset; error saturates at the minimum sample
  task automatic test_reset_defaults();
    send_item(CMD_UPDATE, S32_MAX);
    send_item(CMD_UPDATE, S32_MIN);
    send_item(CMD_CLEAR, 32'hffff_ffff);
  endtask

  task automatic test_extremes();
    drain();
    apply_settings(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_ffff,
                   S32_MIN, S32_MAX, S32_MAX);
    send_item(CMD_CLEAR, S32_MIN);
    send_item(CMD_UPDATE, S32_MIN);
    send_item(CMD_UPDATE, S32_MAX);
    send_item(CMD_UPDATE, 32'h0);
    send_item(CMD_UPDATE, 32'hffff_ffff);
  endtask

  // out_min above out_max: drive pinned to out_max, integral window crossed
  task automatic test_crossed_limits();
    drain();
    apply_settings(32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 32'h0000_8000,
                   32'h0010_0000, 32'hfff0_0000, 32'h0);
    send_item(CMD_CLEAR, 32'h0);
    send_item(CMD_UPDATE, 32'h0020_0000);
    send_item(CMD_UPDATE, 32'hffe0_0000);
    send_item(CMD_UPDATE, 32'h0);
  endtask

  // proportional term alone beyond the output limits
  task automatic test_p_beyond_limits();
    drain();
    apply_settings(32'h0010_0000, 32'h0000_4000, 32'h0000_2000, 32'h0000_c000,
                   32'hffff_0000, 32'h0001_0000, 32'h0005_0000);
    send_item(CMD_CLEAR, 32'h0);
    send_item(CMD_UPDATE, 32'h0);
    send_item(CMD_UPDATE, 32'h000a_0000);
    send_item(CMD_UPDATE, 32'h0000_0001);
  endtask

  task automatic test_backpressure();
    drain();
    pacing   = 1'b0;
    hold_req = 60;
    send_item(CMD_CLEAR, rand_sample());
    repeat (30) send_item(CMD_UPDATE, rand_sample());
    pacing = 1'b1;
    drain();
  endtask

  task automatic test_random();
    int left, run;
    left = RANDOM_ITEMS;
    while (left > 0) begin
      drain();
      randomize_settings();
      run = $urandom_range(20, 100);
      send_item(CMD_CLEAR, rand_sample());
      repeat (run) begin
        if ($urandom_range(0, 19) == 0) send_item(CMD_CLEAR, rand_sample());
        else send_item(CMD_UPDATE, rand_sample());
      end
      left -= run + 1;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_crossed_limits();
    test_p_beyond_limits();
    test_backpressure();
    test_random();
    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_terms.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
